@@ rtl/sha1h_pkg.sv @@
// SHA-1 message hasher: shared types and constants.
// Holds the controller states, the command and status structs, and the SHA-1 constants.
// Depends on nothing; every other file imports it.
package sha1h_pkg;

	localparam int WordW   = 32;
	localparam int RoundW  = 7;
	localparam int IdxW    = 3;
	localparam int CountW  = 61;
	localparam int PosW    = 6;
	localparam int NumChain = 5;
	localparam int NumWin   = 16;

	localparam logic [RoundW-1:0] LastRound = 7'd79;
	localparam logic [IdxW-1:0]   LastWord  = 3'd4;
	localparam logic [PosW-1:0]   LastPos   = 6'd63;
	localparam logic [PosW-1:0]   LenPos    = 6'd56;
	localparam logic [7:0]        PadMarker = 8'h80;

	localparam logic [WordW-1:0] K0 = 32'h5A827999;
	localparam logic [WordW-1:0] K1 = 32'h6ED9EBA1;
	localparam logic [WordW-1:0] K2 = 32'h8F1BBCDC;
	localparam logic [WordW-1:0] K3 = 32'hCA62C1D6;

	localparam logic [WordW-1:0] IV [NumChain] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROUND,
		ST_ADD,
		ST_PAD,
		ST_OUT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic              push_msg;
		logic              push_pad;
		logic              round_en;
		logic              add_chain;
		logic              finish;
		logic [RoundW-1:0] rnd;
		logic [IdxW-1:0]   widx;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic wrap;
		logic pad_final;
	} status_t;

endpackage

@@ rtl/sha1h_ctrl.sv @@
// SHA-1 message hasher: controller state machine.
// Sequences word intake, padding, the 80 rounds and digest output.
// Depends on sha1h_pkg.
module sha1h_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_present,
	input  logic               in_last,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  sha1h_pkg::status_t sts,
	output sha1h_pkg::cmd_t    cmd
);
	import sha1h_pkg::*;

	state_t            state_q, state_d;
	logic [RoundW-1:0] rnd_q;
	logic [IdxW-1:0]   widx_q;
	logic              last_q;
	logic              fin_q;
	logic              in_acc;

	assign in_acc = in_valid && (state_q == ST_IDLE);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (in_present && sts.wrap) state_d = ST_ROUND;
					else if (in_last) state_d = ST_PAD;
				end
			end
			ST_ROUND: begin
				if (rnd_q == LastRound) state_d = ST_ADD;
			end
			ST_ADD: begin
				if (fin_q) state_d = ST_OUT;
				else if (last_q) state_d = ST_PAD;
				else state_d = ST_IDLE;
			end
			ST_PAD: begin
				if (sts.wrap) state_d = ST_ROUND;
			end
			ST_OUT: begin
				if (out_ready && widx_q == LastWord) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs and commands
	always_comb begin
		in_ready      = (state_q == ST_IDLE);
		out_valid     = (state_q == ST_OUT);
		cmd.push_msg  = in_acc && in_present;
		cmd.push_pad  = (state_q == ST_PAD);
		cmd.round_en  = (state_q == ST_ROUND);
		cmd.add_chain = (state_q == ST_ADD);
		cmd.finish    = (state_q == ST_OUT) && out_ready && (widx_q == LastWord);
		cmd.rnd       = rnd_q;
		cmd.widx      = widx_q;
	end

	// state, round counter, word counter and message flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rnd_q   <= '0;
			widx_q  <= '0;
			last_q  <= 1'b0;
			fin_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_acc) begin
				last_q <= in_last;
				fin_q  <= 1'b0;
			end
			if (state_q == ST_PAD && sts.wrap) fin_q <= sts.pad_final;
			if (state_q == ST_ROUND) begin
				if (rnd_q == LastRound) rnd_q <= '0;
				else rnd_q <= rnd_q + 1'b1;
			end
			if (state_q == ST_OUT && out_ready) begin
				if (widx_q == LastWord) begin
					widx_q <= '0;
					last_q <= 1'b0;
					fin_q  <= 1'b0;
				end else begin
					widx_q <= widx_q + 1'b1;
				end
			end
		end
	end

endmodule

@@ rtl/sha1h_datapath.sv @@
// SHA-1 message hasher: datapath.
// Byte packing, padding bytes, rolling schedule, round logic and chaining words.
// Depends on sha1h_pkg; driven by sha1h_ctrl commands.
module sha1h_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [7:0]                  data_byte,
	input  sha1h_pkg::cmd_t             cmd,
	output sha1h_pkg::status_t          sts,
	output logic [sha1h_pkg::WordW-1:0] digest
);
	import sha1h_pkg::*;

	logic [WordW-1:0]  chain_q [NumChain];
	logic [WordW-1:0]  r_q     [NumChain];
	logic [WordW-1:0]  win_q   [NumWin];
	logic [23:0]       acc_q;
	logic [PosW-1:0]   pos_q;
	logic [CountW-1:0] cnt_q;
	logic              mk_q;
	logic              lenblk_q;

	logic              push;
	logic [7:0]        pad_byte;
	logic [7:0]        push_byte;
	logic [WordW-1:0]  word_in;
	logic [63:0]       len_sh;
	logic [WordW-1:0]  w_cur;
	logic [WordW-1:0]  f_val;
	logic [WordW-1:0]  k_val;
	logic [WordW-1:0]  tmp;

	// pick the padding byte: marker, zero or a length byte
	always_comb begin
		len_sh = {cnt_q, 3'b000} << {pos_q[2:0], 3'b000};
		if (!mk_q) pad_byte = PadMarker;
		else if (lenblk_q && pos_q >= LenPos) pad_byte = len_sh[63:56];
		else pad_byte = 8'h00;
	end

	assign push      = cmd.push_msg || cmd.push_pad;
	assign push_byte = cmd.push_pad ? pad_byte : data_byte;
	assign word_in   = {acc_q, push_byte};

	assign sts.wrap      = (pos_q == LastPos);
	assign sts.pad_final = mk_q && lenblk_q && (pos_q == LastPos);

	assign digest = chain_q[cmd.widx];

	// round word, function and constant
	always_comb begin
		if (cmd.rnd < 7'd16) begin
			w_cur = win_q[0];
		end else begin
			w_cur = win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0];
			w_cur = {w_cur[WordW-2:0], w_cur[WordW-1]};
		end
		if (cmd.rnd < 7'd20) begin
			f_val = (r_q[1] & r_q[2]) | (~r_q[1] & r_q[3]);
			k_val = K0;
		end else if (cmd.rnd < 7'd40) begin
			f_val = r_q[1] ^ r_q[2] ^ r_q[3];
			k_val = K1;
		end else if (cmd.rnd < 7'd60) begin
			f_val = (r_q[1] & r_q[2]) | (r_q[1] & r_q[3]) | (r_q[2] & r_q[3]);
			k_val = K2;
		end else begin
			f_val = r_q[1] ^ r_q[2] ^ r_q[3];
			k_val = K3;
		end
		tmp = {r_q[0][WordW-6:0], r_q[0][WordW-1:WordW-5]} + f_val + r_q[4] + w_cur + k_val;
	end

	// schedule window, byte assembly and working variables
	always_ff @(posedge clk) begin
		if (push) begin
			acc_q <= {acc_q[15:0], push_byte};
			if (pos_q[1:0] == 2'd3) begin
				for (int i = 0; i < NumWin - 1; i++) win_q[i] <= win_q[i+1];
				win_q[NumWin-1] <= word_in;
			end
			if (pos_q == LastPos) begin
				for (int i = 0; i < NumChain; i++) r_q[i] <= chain_q[i];
			end
		end
		if (cmd.round_en) begin
			for (int i = 0; i < NumWin - 1; i++) win_q[i] <= win_q[i+1];
			win_q[NumWin-1] <= w_cur;
			r_q[0] <= tmp;
			r_q[1] <= r_q[0];
			r_q[2] <= {r_q[1][1:0], r_q[1][WordW-1:2]};
			r_q[3] <= r_q[2];
			r_q[4] <= r_q[3];
		end
	end

	// chaining words, counts and padding flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NumChain; i++) chain_q[i] <= IV[i];
			pos_q    <= '0;
			cnt_q    <= '0;
			mk_q     <= 1'b0;
			lenblk_q <= 1'b0;
		end else begin
			if (push) pos_q <= pos_q + 1'b1;
			if (cmd.push_msg) cnt_q <= cnt_q + 1'b1;
			if (cmd.push_pad) begin
				if (!mk_q) begin
					mk_q     <= 1'b1;
					lenblk_q <= (pos_q < LenPos) || (pos_q == LastPos);
				end else if (pos_q == LastPos) begin
					lenblk_q <= 1'b1;
				end
			end
			if (cmd.add_chain) begin
				for (int i = 0; i < NumChain; i++) chain_q[i] <= chain_q[i] + r_q[i];
			end
			if (cmd.finish) begin
				for (int i = 0; i < NumChain; i++) chain_q[i] <= IV[i];
				pos_q    <= '0;
				cnt_q    <= '0;
				mk_q     <= 1'b0;
				lenblk_q <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/sha1_message_hasher_top.sv @@
// SHA-1 message hasher: top level.
// Joins sha1h_ctrl and sha1h_datapath to the stream ports; depends on sha1h_pkg.
//
// Feed the message one word per byte (tuser high) and mark the final word with tlast;
// a word with tuser low carries no byte, so tlast alone ends an empty message. Byte words
// are taken one per cycle while s_tready is high; the 64th byte of a block starts the
// 80-round compression, one round per cycle, followed by the chaining add. At the end the
// padding goes in one byte per cycle, paused for each compression, with one or two more
// compressions (two when the length needs a second block), then the digest leaves as
// five words, most significant first, with tlast on the fifth.
// Input is held off (s_tready low) for each compression and its chaining add, and from
// a tlast word until the last digest word has been taken.
module sha1_message_hasher_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // byte_present
	input  logic        s_tlast,   // end_of_message
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_number, [39:35] zero
	output logic        m_tlast    // final_word
);
	import sha1h_pkg::*;

	cmd_t             cmd;
	status_t          sts;
	logic [WordW-1:0] digest;

	sha1h_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_present (s_tuser),
		.in_last    (s_tlast),
		.in_ready   (s_tready),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.sts        (sts),
		.cmd        (cmd)
	);

	sha1h_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.data_byte (s_tdata),
		.cmd       (cmd),
		.sts       (sts),
		.digest    (digest)
	);

	// pack the result word
	assign m_tdata = {5'b00000, cmd.widx, digest};
	assign m_tlast = (cmd.widx == LastWord);

endmodule
